/* hw/rtl/b64enc_pkg.sv */
// Package for the Base64 stream encoder: transaction payload types, the
// phase codes and the standard-alphabet character mapping.
// No dependencies.
package b64enc_pkg;

   localparam int unsigned CharWidth  = 7;
   localparam int unsigned MaxChars   = 4;
   localparam int unsigned CountWidth = $clog2(MaxChars + 1);

   localparam logic [CharWidth-1:0] PAD_CHAR   = 7'h3D;
   localparam logic [CharWidth-1:0] PLUS_CHAR  = 7'h2B;
   localparam logic [CharWidth-1:0] SLASH_CHAR = 7'h2F;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_data_type;

   typedef struct packed {
      logic [CharWidth-1:0] out_char;
      logic                 end_of_text;
   } rsp_data_type;

   // byte position within the current three-byte group
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   function automatic logic [CharWidth-1:0] b64_char(input logic [5:0] v);
      logic [CharWidth-1:0] ch;
      if (v < 6'd26) begin
         ch = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         ch = 7'h61 + {1'b0, v - 6'd26};
      end else if (v < 6'd62) begin
         ch = 7'h30 + {1'b0, v - 6'd52};
      end else if (v == 6'd62) begin
         ch = PLUS_CHAR;
      end else begin
         ch = SLASH_CHAR;
      end
      return ch;
   endfunction

endpackage

/* hw/rtl/base64_stream_encoder_top.sv */
// Base64 stream encoder top level: one byte per request transaction, one
// character per response transaction. Depends on b64enc_pkg.
//
//   Channel | Ports                          | Direction | Carries
//   --------+--------------------------------+-----------+---------------------------
//   req     | req_valid, req_ready, req_data | in        | data_byte, final_byte
//   rsp     | rsp_valid, rsp_ready, rsp_data | out       | out_char, end_of_text
//   csr     | csr_valid, csr_ready, csr_data | in        | emit_padding (always ready)
//
// A byte is encoded in the cycle it is accepted into a four-entry character
// buffer; its characters then pass through the output register to rsp.
// The rsp port moves one character per cycle while rsp_ready is held high; a
// byte produces 1 to 4 characters, and the next byte is taken in the cycle the
// last buffered character moves into the output register.
// Synchronous reset clears phase, leftover bits and buffer, and sets
// emit_padding to 1. A stall on rsp holds the output register and the buffered
// characters, and req_ready stays low while characters wait in the buffer.
module base64_stream_encoder_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  b64enc_pkg::req_data_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output b64enc_pkg::rsp_data_type  rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_data
);
   import b64enc_pkg::*;

   logic                  pad_en_ff, pad_en_in;
   phase_type             phase_ff, phase_in;
   logic [3:0]            left_ff, left_in;
   rsp_data_type          buf_ff [MaxChars];
   rsp_data_type          buf_in [MaxChars];
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   rsp_data_type          enc [MaxChars];
   logic [CountWidth-1:0] enc_count;
   logic                  pop;
   logic                  req_fire;

   // move the head of the buffer into the output register when it is free
   assign pop       = (count_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (count_ff == '0) || ((count_ff == CountWidth'(1)) && pop);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // encode one byte into up to four characters
   always_comb begin
      logic [7:0] b;
      logic       fin;
      b         = req_data.data_byte;
      fin       = req_data.final_byte;
      phase_in  = phase_ff;
      left_in   = left_ff;
      enc_count = '0;
      for (int i = 0; i < MaxChars; i++) begin
         enc[i] = '{out_char: PAD_CHAR, end_of_text: 1'b0};
      end
      case (phase_ff)
         PH_SECOND: begin
            enc[0].out_char = b64_char({left_ff[1:0], b[7:4]});
            if (fin) begin
               enc[1].out_char    = b64_char({b[3:0], 2'b00});
               enc[1].end_of_text = !pad_en_ff;
               enc[2].end_of_text = 1'b1;
               enc_count          = pad_en_ff ? CountWidth'(3) : CountWidth'(2);
               phase_in           = PH_FIRST;
               left_in            = '0;
            end else begin
               enc_count = CountWidth'(1);
               phase_in  = PH_THIRD;
               left_in   = b[3:0];
            end
         end
         PH_THIRD: begin
            enc[0].out_char    = b64_char({left_ff, b[7:6]});
            enc[1].out_char    = b64_char(b[5:0]);
            enc[1].end_of_text = fin;
            enc_count          = CountWidth'(2);
            phase_in           = PH_FIRST;
            left_in            = '0;
         end
         default: begin
            // first byte of a group; the unused code falls here too
            enc[0].out_char = b64_char(b[7:2]);
            if (fin) begin
               enc[1].out_char    = b64_char({b[1:0], 4'b0000});
               enc[1].end_of_text = !pad_en_ff;
               enc[3].end_of_text = 1'b1;
               enc_count          = pad_en_ff ? CountWidth'(4) : CountWidth'(2);
               phase_in           = PH_FIRST;
               left_in            = '0;
            end else begin
               enc_count = CountWidth'(1);
               phase_in  = PH_SECOND;
               left_in   = {2'b00, b[1:0]};
            end
         end
      endcase
   end

   always_comb begin
      pad_en_in    = csr_valid ? csr_data : pad_en_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      for (int i = 0; i < MaxChars; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (pop) begin
         rsp_data_in  = buf_ff[0];
         rsp_valid_in = 1'b1;
         count_in     = count_ff - CountWidth'(1);
         for (int i = 0; i < MaxChars - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // accepted only when the buffer is empty or empties this cycle: overwrite it
      if (req_fire) begin
         count_in = enc_count;
         for (int i = 0; i < MaxChars; i++) begin
            buf_in[i] = enc[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_en_ff    <= 1'b1;
         phase_ff     <= PH_FIRST;
         left_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pad_en_ff    <= pad_en_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         if (req_fire) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < MaxChars; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(MaxChars))
      else $error("character buffer count out of range");

   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("phase reached unused code");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> count_ff != '0)
      else $error("accepted byte left no characters");

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped character not presented");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.end_of_text && (count_ff == '0)
         |-> (phase_ff == PH_FIRST) && (left_ff == '0))
      else $error("message ended without returning to idle");

endmodule
